FILE: hw/rtl/slen_pkg.sv
// shared types, constants and helper functions of the string literal escape normaliser
package slen_pkg;

	// widths of the line and column counters
	localparam int LINE_WIDTH = 20;
	localparam int COL_WIDTH  = 16;

	// fixed widths of the position fields on the ports
	localparam int LINE_PORT_W = 20;
	localparam int COL_PORT_W  = 16;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [7:0]             byte_t;
	typedef logic [LINE_WIDTH-1:0]  line_t;
	typedef logic [COL_WIDTH-1:0]   col_t;
	typedef logic [LINE_PORT_W-1:0] line_port_t;
	typedef logic [COL_PORT_W-1:0]  col_port_t;
	typedef logic [QPTR_W-1:0]      qptr_t;
	typedef logic [QCNT_W-1:0]      qcnt_t;

	localparam line_t LINE_MAX = '1;
	localparam col_t  COL_MAX  = '1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_EOI = 2'd1,
		ST_HEX = 2'd2
	} status_t;

	// escape decoding phase
	typedef enum logic [4:0] {
		PH_NONE = 5'b00001,
		PH_ESC  = 5'b00010,
		PH_HEX1 = 5'b00100,
		PH_HEX2 = 5'b01000,
		PH_CR   = 5'b10000
	} phase_t;

	// characters of interest
	localparam byte_t CH_NUL    = 8'h00;
	localparam byte_t CH_LF     = 8'h0A;
	localparam byte_t CH_CR     = 8'h0D;
	localparam byte_t CH_BS_ESC = 8'h08;
	localparam byte_t CH_TAB    = 8'h09;
	localparam byte_t CH_QUOTE  = 8'h22;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_X      = 8'h78;
	localparam byte_t CH_N      = 8'h6E;
	localparam byte_t CH_B      = 8'h62;
	localparam byte_t CH_T      = 8'h74;
	localparam byte_t CH_R      = 8'h72;

	// one queued command: optional four-byte hex escape, then an optional tail byte
	typedef struct packed {
		logic    code_en;
		byte_t   code_hi;
		byte_t   code_lo;
		logic    tail_en;
		byte_t   tail_byte;
		logic    last;
		status_t status;
		line_t   line;
		col_t    col;
	} entry_t;

	// ascii hex digit for a nibble
	function automatic byte_t hex_char(input logic [3:0] v, input logic upper);
		byte_t r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'b0, v};
		end else if (upper) begin
			r = 8'h41 + {4'b0, v} - 8'd10;
		end else begin
			r = 8'h61 + {4'b0, v} - 8'd10;
		end
		return r;
	endfunction

	// true for 0-9, a-f, A-F
	function automatic logic is_hex(input byte_t b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

endpackage

FILE: hw/rtl/slen_front.sv
// front part: accepts source bytes, runs the escape decoder and queues commands
module slen_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   in_byte,
	input  logic                         start_req,
	input  logic [19:0]                  start_line,
	input  logic [15:0]                  start_col,
	input  logic                         cfg_valid,
	input  logic                         cfg_upper,
	input  logic                         q_full,
	output logic                         push,
	output slen_pkg::entry_t             push_entry
);
	import slen_pkg::*;

	logic    in_literal_q;
	phase_t  phase_q;
	byte_t   first_hex_q;
	line_t   line_q;
	col_t    col_q;
	logic    upper_q;

	logic    nx_literal;
	phase_t  nx_phase;
	byte_t   nx_first;
	line_t   nx_line;
	col_t    nx_col;
	line_t   line_inc;
	col_t    col_inc;
	line_t   line_load;
	col_t    col_load;
	logic    do_plain;
	logic    accept;
	entry_t  e;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// saturating position helpers
	assign line_inc  = (line_q == LINE_MAX) ? line_q : line_q + line_t'(1);
	assign col_inc   = (col_q == COL_MAX) ? col_q : col_q + col_t'(1);
	assign line_load = (start_line > 20'(LINE_MAX)) ? LINE_MAX : line_t'(start_line);
	assign col_load  = (start_col > 16'(COL_MAX)) ? COL_MAX : col_t'(start_col);

	// escape decoder and command building
	always_comb begin
		nx_literal = in_literal_q;
		nx_phase   = phase_q;
		nx_first   = first_hex_q;
		nx_line    = line_q;
		nx_col     = col_q;
		do_plain   = 1'b0;
		e          = '0;
		e.status   = ST_OK;
		if (start_req) begin
			nx_line     = line_load;
			nx_col      = col_load;
			nx_literal  = 1'b1;
			nx_phase    = PH_NONE;
			nx_first    = CH_NUL;
			e.tail_en   = 1'b1;
			e.tail_byte = CH_QUOTE;
		end else if (in_literal_q) begin
			case (phase_q)
				PH_ESC: begin
					nx_phase = PH_NONE;
					if (in_byte == CH_NUL) begin
						nx_literal = 1'b0;
						e.tail_en  = 1'b1;
						e.last     = 1'b1;
						e.status   = ST_EOI;
					end else begin
						nx_col = col_inc;
						if (in_byte == CH_X) begin
							nx_phase = PH_HEX1;
						end else if (in_byte == CH_CR) begin
							nx_phase = PH_CR;
						end else if (in_byte == CH_LF) begin
							nx_line = line_inc;
							nx_col  = '0;
						end else begin
							e.code_en = 1'b1;
							if (in_byte == CH_N) begin
								e.code_hi = hex_char(CH_LF[7:4], upper_q);
								e.code_lo = hex_char(CH_LF[3:0], upper_q);
							end else if (in_byte == CH_B) begin
								e.code_hi = hex_char(CH_BS_ESC[7:4], upper_q);
								e.code_lo = hex_char(CH_BS_ESC[3:0], upper_q);
							end else if (in_byte == CH_T) begin
								e.code_hi = hex_char(CH_TAB[7:4], upper_q);
								e.code_lo = hex_char(CH_TAB[3:0], upper_q);
							end else if (in_byte == CH_R) begin
								e.code_hi = hex_char(CH_CR[7:4], upper_q);
								e.code_lo = hex_char(CH_CR[3:0], upper_q);
							end else begin
								e.code_hi = hex_char(in_byte[7:4], upper_q);
								e.code_lo = hex_char(in_byte[3:0], upper_q);
							end
						end
					end
				end
				PH_HEX1: begin
					if (!is_hex(in_byte)) begin
						nx_literal = 1'b0;
						nx_phase   = PH_NONE;
						e.tail_en  = 1'b1;
						e.last     = 1'b1;
						e.status   = ST_HEX;
					end else begin
						nx_col   = col_inc;
						nx_first = in_byte;
						nx_phase = PH_HEX2;
					end
				end
				PH_HEX2: begin
					nx_phase = PH_NONE;
					if (!is_hex(in_byte)) begin
						nx_literal = 1'b0;
						e.tail_en  = 1'b1;
						e.last     = 1'b1;
						e.status   = ST_HEX;
					end else begin
						nx_col    = col_inc;
						e.code_en = 1'b1;
						e.code_hi = first_hex_q;
						e.code_lo = in_byte;
					end
				end
				PH_CR: begin
					nx_phase = PH_NONE;
					if (in_byte == CH_LF) begin
						nx_line = line_inc;
						nx_col  = '0;
					end else begin
						// lone escaped cr: emit its code, then the byte as plain text
						e.code_en = 1'b1;
						e.code_hi = hex_char(CH_CR[7:4], upper_q);
						e.code_lo = hex_char(CH_CR[3:0], upper_q);
						do_plain  = 1'b1;
					end
				end
				PH_NONE: begin
					do_plain = 1'b1;
				end
				default: begin
					nx_phase = PH_NONE;
					do_plain = 1'b1;
				end
			endcase

			// plain text byte
			if (do_plain) begin
				if (in_byte == CH_NUL) begin
					nx_literal = 1'b0;
					nx_phase   = PH_NONE;
					e.tail_en  = 1'b1;
					e.last     = 1'b1;
					e.status   = ST_EOI;
				end else if (in_byte == CH_QUOTE) begin
					nx_col      = col_inc;
					nx_literal  = 1'b0;
					nx_phase    = PH_NONE;
					e.tail_en   = 1'b1;
					e.tail_byte = in_byte;
					e.last      = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					nx_col   = col_inc;
					nx_phase = PH_ESC;
				end else begin
					if (in_byte == CH_LF) begin
						nx_line = line_inc;
						nx_col  = '0;
					end else begin
						nx_col = col_inc;
					end
					e.tail_en   = 1'b1;
					e.tail_byte = in_byte;
				end
			end
		end
		e.line = nx_line;
		e.col  = nx_col;
	end

	assign push       = accept && (e.code_en || e.tail_en);
	assign push_entry = e;

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_literal_q <= 1'b0;
			phase_q      <= PH_NONE;
			first_hex_q  <= '0;
			line_q       <= '0;
			col_q        <= '0;
		end else if (accept) begin
			in_literal_q <= nx_literal;
			phase_q      <= nx_phase;
			first_hex_q  <= nx_first;
			line_q       <= nx_line;
			col_q        <= nx_col;
		end
	end

	// hex case register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b0;
		end else if (cfg_valid) begin
			upper_q <= cfg_upper;
		end
	end

endmodule

FILE: hw/rtl/slen_queue.sv
// short command queue between the front and back parts
module slen_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  slen_pkg::entry_t push_entry,
	input  logic             pop,
	output slen_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import slen_pkg::*;

	entry_t slots_q [QUEUE_DEPTH];
	qptr_t  wptr_q;
	qptr_t  rptr_q;
	qcnt_t  count_q;
	logic   do_push;
	logic   do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == qcnt_t'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + qptr_t'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + qptr_t'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + qcnt_t'(1);
				2'b01:   count_q <= count_q - qcnt_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/slen_back.sv
// back part: expands queued commands into result bytes through an output register
module slen_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  slen_pkg::entry_t                    head,
	input  logic                                empty,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_byte,
	output logic                                last,
	output logic [1:0]                          status,
	output logic [slen_pkg::LINE_PORT_W-1:0]    line_now,
	output logic [slen_pkg::COL_PORT_W-1:0]     col_now
);
	import slen_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	byte_t      byte_q;
	logic       last_q;
	status_t    status_q;
	line_port_t line_q;
	col_port_t  col_q;

	logic       load;
	logic       final_byte;
	byte_t      sel_byte;

	assign load = !empty && (!valid_q || !out_stall);

	// pick the byte of the current command
	always_comb begin
		sel_byte = head.tail_byte;
		if (head.code_en) begin
			case (idx_q)
				3'd0:    sel_byte = CH_BSLASH;
				3'd1:    sel_byte = CH_X;
				3'd2:    sel_byte = head.code_hi;
				3'd3:    sel_byte = head.code_lo;
				default: sel_byte = head.tail_byte;
			endcase
		end
		if (head.code_en) begin
			final_byte = head.tail_en ? (idx_q == 3'd4) : (idx_q == 3'd3);
		end else begin
			final_byte = 1'b1;
		end
	end

	assign pop = load && final_byte;

	// byte index within the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= final_byte ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= sel_byte;
			last_q   <= final_byte && head.last;
			status_q <= final_byte ? head.status : ST_OK;
			line_q   <= line_port_t'(head.line);
			col_q    <= col_port_t'(head.col);
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign status    = status_q;
	assign line_now  = line_q;
	assign col_now   = col_q;

endmodule

FILE: hw/rtl/string_literal_escape_normalizer.sv
// top level of the string literal escape normaliser
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_stall   | in_byte, start_req, start_line, start_col
//  out      | out_valid / out_stall | out_byte, last, status, line_now, col_now
//  cfg      | cfg_valid / cfg_ready | hex_upper_case
//
// one source byte is taken every cycle while the command queue has room
// the back part sends one result a cycle unless stalled; a source byte gives 0 to 5 bytes
// the four-entry command queue absorbs escape bursts; in_stall is the queue full
// reset clears decoder state, queue pointers and the output valid; no clearing pass
// out_stall holds the output register, the front keeps going until the queue fills
module string_literal_escape_normalizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       in_byte,
	input  logic                             start_req,
	input  logic [19:0]                      start_line,
	input  logic [15:0]                      start_col,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             last,
	output logic [1:0]                       status,
	output logic [slen_pkg::LINE_PORT_W-1:0] line_now,
	output logic [slen_pkg::COL_PORT_W-1:0]  col_now,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             hex_upper_case
);
	import slen_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   empty;
	logic   full;

	assign cfg_ready = 1'b1;

	// decoder
	slen_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.start_req  (start_req),
		.start_line (start_line),
		.start_col  (start_col),
		.cfg_valid  (cfg_valid),
		.cfg_upper  (hex_upper_case),
		.q_full     (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// command queue
	slen_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	// result expansion
	slen_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status),
		.line_now  (line_now),
		.col_now   (col_now)
	);

endmodule

FILE: hw/rtl/slen_checker.sv
// port-level checks of the string literal escape normaliser and their binding
module slen_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last,
	input logic [1:0] status
);
	import slen_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled result changed");

	// an error status always ends the literal
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last)
		else $error("error result without last");

	// an error result carries a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (out_byte == CH_NUL))
		else $error("error result with non-zero byte");

	// a clean end is the closing quote
	a_ok_quote: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && (status == ST_OK) |-> (out_byte == CH_QUOTE))
		else $error("clean end is not a quote");

endmodule

bind string_literal_escape_normalizer slen_checker u_slen_checker (.*);
